### rtl/core/tae_pkg.sv
// Shared types, field widths and operation codes of the temporal action ensembler.
`default_nettype none

package tae_pkg;

  // Parameter defaults.
  localparam int CHUNK_LEN_DEF = 64;
  localparam int NUM_DIMS_DEF  = 8;

  // Fixed field widths.
  localparam int KIND_W = 2;
  localparam int SLOT_W = 6;
  localparam int DIM_W  = 3;
  localparam int VAL_W  = 16;
  localparam int WGT_W  = 16;
  localparam int CUM_W  = 22;

  // Blend arithmetic widths: numerator magnitude plus rounding and quotient.
  localparam int NUM_W = 40;
  localparam int QUO_W = 17;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 4;

  localparam logic [CUM_W-1:0] CUM_MAX = {CUM_W{1'b1}};

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ELEM   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // One queued operation.
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [SLOT_W-1:0]       slot;
    logic [DIM_W-1:0]        dim;
    logic signed [VAL_W-1:0] act;
    logic [WGT_W-1:0]        wgt;
  } tae_op_t;

  // Request to the divider.
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  dividend;
    logic [CUM_W-1:0]  divisor;
  } tae_div_req_t;

  // Answer from the divider.
  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUO_W-1:0]  quot;
  } tae_div_res_t;

endpackage

`default_nettype wire

### rtl/core/tae_front.sv
// Front end: accepts input transfers, drops meaningless ones and queues the rest.
`default_nettype none

module tae_front #(
  parameter int CHUNK_LEN = tae_pkg::CHUNK_LEN_DEF,
  parameter int NUM_DIMS  = tae_pkg::NUM_DIMS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [tae_pkg::KIND_W-1:0]    in_kind,
  input  wire [tae_pkg::SLOT_W-1:0]    in_slot,
  input  wire [tae_pkg::DIM_W-1:0]     in_dim_index,
  input  wire signed [tae_pkg::VAL_W-1:0] in_action_value,
  input  wire [tae_pkg::WGT_W-1:0]     in_weight_value,
  output logic                         q_valid,
  output tae_pkg::tae_op_t             q_op,
  input  wire                          q_pop
);
  import tae_pkg::*;

  localparam int QPW = $clog2(Q_DEPTH);
  localparam int QCW = $clog2(Q_DEPTH + 1);

  tae_op_t          mem_r [Q_DEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             keep;
  logic             push;
  tae_op_t          op_in;

  // Classify: only in-range loads and elements and clears do any work.
  always_comb begin
    keep = 1'b0;
    case (in_kind)
      KIND_LOAD:  keep = (32'(in_slot) < CHUNK_LEN);
      KIND_ELEM:  keep = (32'(in_slot) < CHUNK_LEN) && (32'(in_dim_index) < NUM_DIMS);
      KIND_CLEAR: keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign op_in    = '{kind: in_kind, slot: in_slot, dim: in_dim_index,
                      act: in_action_value, wgt: in_weight_value};
  assign in_stall = (cnt_r == QCW'(Q_DEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt_r != '0);
  assign q_op     = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tae_div.sv
// Restoring divider that produces one quotient bit per cycle for the blend.
`default_nettype none

module tae_div (
  input  wire                    clk,
  input  wire                    rst_n,
  input  tae_pkg::tae_div_req_t  req,
  output tae_pkg::tae_div_res_t  res
);
  import tae_pkg::*;

  localparam int STW = $clog2(QUO_W + 1);

  logic             busy_r, busy_nxt;
  logic [STW-1:0]   step_r, step_nxt;
  logic             done_r, done_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CUM_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] low_r, low_nxt;
  logic [CUM_W-1:0] dvs_r, dvs_nxt;
  logic [CUM_W:0]   trial;
  logic             ge;
  logic             too_big;

  // A quotient that does not fit in QUO_W bits is flagged as overflow without dividing.
  assign too_big = (req.dividend >= {req.divisor, {QUO_W{1'b0}}});
  assign trial   = {rem_r, low_r[QUO_W-1]};
  assign ge      = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      dvs_nxt = req.divisor;
      rem_nxt = req.dividend[NUM_W-2:QUO_W];
      low_nxt = req.dividend[QUO_W-1:0];
      ovf_nxt = too_big;
      if (too_big) begin
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        step_nxt = '0;
      end
    end else if (busy_r) begin
      // Shift in the next dividend bit and subtract where it fits.
      rem_nxt  = ge ? CUM_W'(trial - {1'b0, dvs_r}) : trial[CUM_W-1:0];
      low_nxt  = {low_r[QUO_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STW'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r <= ovf_nxt;
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res = '{done: done_r, ovf: ovf_r, quot: low_r};

endmodule

`default_nettype wire

### rtl/core/tae_back.sv
// Back end: weight tables, history ring, blend sequencer and output register.
`default_nettype none

module tae_back #(
  parameter int CHUNK_LEN = tae_pkg::CHUNK_LEN_DEF,
  parameter int NUM_DIMS  = tae_pkg::NUM_DIMS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          q_valid,
  input  tae_pkg::tae_op_t             q_op,
  output logic                         q_pop,
  output tae_pkg::tae_div_req_t        div_req,
  input  tae_pkg::tae_div_res_t        div_res,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic signed [tae_pkg::VAL_W-1:0] out_action_out,
  output logic [tae_pkg::DIM_W-1:0]    out_dim,
  output logic                         out_last_dim
);
  import tae_pkg::*;

  localparam int HIST_POS = CHUNK_LEN - 1;
  localparam int SW  = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;
  localparam int PW  = (HIST_POS > 1) ? $clog2(HIST_POS) : 1;
  localparam int HD  = HIST_POS * NUM_DIMS;
  localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
  localparam int CW  = $clog2(CHUNK_LEN + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CNT    = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_SUM    = 4'd3;
  localparam logic [3:0] S_ABS    = 4'd4;
  localparam logic [3:0] S_DSTART = 4'd5;
  localparam logic [3:0] S_DWAIT  = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Weight and cumulative tables, with valid bits standing for the zero reset.
  logic [WGT_W-1:0]  wtab [CHUNK_LEN];
  logic [CUM_W-1:0]  ctab [CHUNK_LEN];
  logic [CHUNK_LEN-1:0] wvld_r;
  logic [CUM_W-1:0]  acc_r;

  // History ring and per-position counts.
  logic signed [VAL_W-1:0] hist [HD];
  logic [CW-1:0]     cmem [HIST_POS];
  logic [HIST_POS-1:0] cvld_r;
  logic [PW-1:0]     head_r;
  logic              has_hist_r;

  // Sequencer state.
  logic [3:0]        state_r, state_nxt;
  tae_op_t           op_r;
  logic [PW-1:0]     phys_r;
  logic [HAW-1:0]    haddr_r;

  // Registered memory read data.
  logic signed [VAL_W-1:0] hist_rd_r;
  logic [CW-1:0]     cnt_rd_r;
  logic              cnt_vld_rd_r;
  logic [WGT_W-1:0]  w_rd_r;
  logic [CUM_W-1:0]  cm1_rd_r, ck_rd_r;
  logic              tv_k_r, tv_km1_r;

  // Datapath registers.
  logic signed [VAL_W+CUM_W:0]   p1_r;
  logic signed [VAL_W+WGT_W:0]   p2_r;
  logic signed [NUM_W-1:0]       n_r;
  logic [NUM_W-1:0]              x_r;
  logic [CUM_W-1:0]              d_r;
  logic                          neg_r;
  logic signed [VAL_W-1:0]       val_r;
  logic                          out_valid_r;
  logic signed [VAL_W-1:0]       out_val_r;
  logic [DIM_W-1:0]              out_dim_r;
  logic                          out_last_r;

  // Decoded element properties.
  logic              is_first, is_last, last_d;
  logic [CW-1:0]     c_raw;
  logic [CW:0]       c_inc;
  logic [SW-1:0]     k, km1;
  logic [PW:0]       psum;
  logic [PW-1:0]     phys;
  logic [HAW-1:0]    haddr;
  logic [CUM_W:0]    load_sum;
  logic [CUM_W-1:0]  load_cum;
  logic [SW-1:0]     load_idx;
  logic              do_load, do_clear, do_elem;
  logic              hist_we, cnt_we, emit, shift_win;
  logic signed [VAL_W-1:0] hist_wd;
  logic [CW-1:0]     cnt_wd;
  logic [NUM_W-1:0]  mag;
  logic signed [VAL_W-1:0] div_val;

  assign is_first = (op_r.slot == '0);
  assign is_last  = (32'(op_r.slot) == CHUNK_LEN - 1);
  assign last_d   = (32'(op_r.dim) == NUM_DIMS - 1);

  // Ring slot of the incoming element: head plus position, wrapped once.
  assign psum  = {1'b0, head_r} + (PW+1)'(q_op.slot);
  assign phys  = (psum >= (PW+1)'(HIST_POS)) ? PW'(psum - (PW+1)'(HIST_POS)) : PW'(psum);
  assign haddr = HAW'(phys) * HAW'(NUM_DIMS) + HAW'(q_op.dim);

  // Count seen by the blend, clamped to the table range.
  assign c_raw = cnt_vld_rd_r ? cnt_rd_r : '0;
  assign c_inc = {1'b0, c_raw} + 1'b1;
  always_comb begin
    if (c_raw == '0) begin
      k = SW'(1);
    end else if (32'(c_raw) > HIST_POS) begin
      k = SW'(HIST_POS);
    end else begin
      k = SW'(c_raw);
    end
    km1 = k - 1'b1;
  end

  // Weight load: running sum, restarted at index zero, saturated.
  assign load_idx = SW'(q_op.slot);
  assign load_sum = ((q_op.slot == '0) ? {(CUM_W+1){1'b0}} : {1'b0, acc_r})
                  + (CUM_W+1)'(q_op.wgt);
  assign load_cum = load_sum[CUM_W] ? CUM_MAX : load_sum[CUM_W-1:0];

  assign do_load  = (state_r == S_IDLE) && q_valid && (q_op.kind == KIND_LOAD);
  assign do_clear = (state_r == S_IDLE) && q_valid && (q_op.kind == KIND_CLEAR);
  assign do_elem  = (state_r == S_IDLE) && q_valid && (q_op.kind == KIND_ELEM);
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  // Rounded quotient with sign restored, saturated to the action range.
  always_comb begin
    if (!neg_r) begin
      div_val = (div_res.ovf || (div_res.quot > QUO_W'(32'(VAL_MAX))))
              ? VAL_MAX : VAL_W'(div_res.quot);
    end else begin
      div_val = (div_res.ovf || (div_res.quot > QUO_W'(32'(VAL_MAX) + 1)))
              ? VAL_MIN : VAL_W'(-div_res.quot);
    end
  end

  assign mag = neg_r ? NUM_W'(-n_r) : NUM_W'(n_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    hist_we   = 1'b0;
    hist_wd   = val_r;
    cnt_we    = 1'b0;
    cnt_wd    = CW'(1);
    emit      = 1'b0;
    shift_win = 1'b0;
    div_req   = '{start: 1'b0, dividend: x_r, divisor: d_r};
    case (state_r)
      S_IDLE: begin
        if (do_elem) begin
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        if (is_last) begin
          // Final chunk position is stored raw and closes the chunk.
          hist_we = 1'b1;
          hist_wd = op_r.act;
          if (last_d) begin
            cnt_we    = 1'b1;
            shift_win = 1'b1;
          end
          state_nxt = S_IDLE;
        end else if (!has_hist_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:    state_nxt = S_SUM;
      S_SUM:    state_nxt = S_ABS;
      S_ABS:    state_nxt = (d_r == '0) ? S_FIN : S_DSTART;
      S_DSTART: begin
        div_req.start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_res.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (is_first) begin
          if (!out_valid_r || !out_stall) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          hist_we = 1'b1;
          if (last_d) begin
            cnt_we = 1'b1;
            if (has_hist_r) begin
              cnt_wd = (32'(c_inc) > CHUNK_LEN) ? CW'(CHUNK_LEN) : CW'(c_inc);
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wvld_r      <= '0;
      cvld_r      <= '0;
      acc_r       <= '0;
      head_r      <= '0;
      has_hist_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_load) begin
        wvld_r[load_idx] <= 1'b1;
        acc_r            <= load_cum;
      end
      if (do_clear) begin
        cvld_r     <= '0;
        head_r     <= '0;
        has_hist_r <= 1'b0;
      end
      if (cnt_we) begin
        cvld_r[phys_r] <= 1'b1;
      end
      if (shift_win) begin
        head_r     <= (32'(head_r) == HIST_POS - 1) ? '0 : head_r + 1'b1;
        has_hist_r <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Table memories: one write port, two read ports.
  always_ff @(posedge clk) begin
    if (do_load) begin
      wtab[load_idx] <= q_op.wgt;
      ctab[load_idx] <= load_cum;
    end
    if (state_r == S_CNT) begin
      w_rd_r   <= wtab[k];
      ck_rd_r  <= ctab[k];
      cm1_rd_r <= ctab[km1];
      tv_k_r   <= wvld_r[k];
      tv_km1_r <= wvld_r[km1];
    end
  end

  // History memory.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[haddr_r] <= hist_wd;
    end
    if (do_elem) begin
      hist_rd_r <= hist[haddr];
    end
  end

  // Count memory.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cmem[phys_r] <= cnt_wd;
    end
    if (do_elem) begin
      cnt_rd_r     <= cmem[phys];
      cnt_vld_rd_r <= cvld_r[phys];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (do_elem) begin
      op_r    <= q_op;
      phys_r  <= phys;
      haddr_r <= haddr;
    end
    if (state_r == S_CNT) begin
      val_r <= op_r.act;
    end
    if (state_r == S_MUL) begin
      p1_r <= (VAL_W+CUM_W+1)'(hist_rd_r)
            * (VAL_W+CUM_W+1)'($signed({1'b0, (tv_km1_r ? cm1_rd_r : {CUM_W{1'b0}})}));
      p2_r <= (VAL_W+WGT_W+1)'(op_r.act)
            * (VAL_W+WGT_W+1)'($signed({1'b0, (tv_k_r ? w_rd_r : {WGT_W{1'b0}})}));
      d_r  <= tv_k_r ? ck_rd_r : '0;
    end
    if (state_r == S_SUM) begin
      n_r <= NUM_W'(p1_r) + NUM_W'(p2_r);
    end
    if (state_r == S_ABS) begin
      neg_r <= n_r[NUM_W-1];
      val_r <= hist_rd_r;
    end
    if (state_r == S_DSTART) begin
      x_r <= x_r;
    end else if (state_r == S_ABS) begin
      x_r <= (n_r[NUM_W-1] ? NUM_W'(-n_r) : NUM_W'(n_r)) + NUM_W'(d_r >> 1);
    end
    if ((state_r == S_DWAIT) && div_res.done) begin
      val_r <= div_val;
    end
    if (emit) begin
      out_val_r  <= val_r;
      out_dim_r  <= op_r.dim;
      out_last_r <= last_d;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action_out = out_val_r;
  assign out_dim        = out_dim_r;
  assign out_last_dim   = out_last_r;

  // The window only moves once history exists.
  a_head_needs_history: assert property (@(posedge clk) disable iff (!rst_n)
    !has_hist_r |-> (head_r == '0))
    else $error("ring head moved without history");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(head_r) < HIST_POS)
    else $error("ring head out of range");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DWAIT))
    else $error("divider finished while not awaited");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN) && $past(is_first))
    else $error("result raised outside the final step of a position-0 element");

  a_mag_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSTART) |-> (x_r >= mag))
    else $error("divider dividend smaller than numerator magnitude");

endmodule

`default_nettype wire

### rtl/core/temporal_action_ensembler.sv
// Top level of the temporal action ensembler: front queue, blend back end, divider.
//
// Usage: software first sends weight words (kind load) in index order; they are
// summed into a cumulative table. Chunk elements (kind element) then arrive
// position by position, dimension by dimension; every position-0 element yields
// one result transfer carrying the blended action, its dimension and a flag on
// the final dimension. A clear item drops the history but keeps the weights.
// Both channels transfer on a clock edge with valid high and stall low.
// The back end does loads and clears in its idle state and takes the next item
// from the queue only when idle again. A final-position element is stored raw
// after the count step, a first-chunk element goes on to the final step, and a
// blended element passes multiply, sum and magnitude steps, then waits on the
// one-bit-per-cycle divider that rounds the weighted average. A four-entry queue
// between the input and the back end takes transfers while the back end is busy.
// Reset (synchronous, rst_n low) empties the queue and the output register and
// clears weights, counts and history state; no clearing pass is needed.
// While the receiver stalls, the result holds and the back end waits with the
// next result; the queue then fills and the input stalls.
`default_nettype none

module temporal_action_ensembler #(
  parameter int CHUNK_LEN = tae_pkg::CHUNK_LEN_DEF,
  parameter int NUM_DIMS  = tae_pkg::NUM_DIMS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [tae_pkg::KIND_W-1:0]        in_kind,
  input  wire [tae_pkg::SLOT_W-1:0]        in_slot,
  input  wire [tae_pkg::DIM_W-1:0]         in_dim_index,
  input  wire signed [tae_pkg::VAL_W-1:0]  in_action_value,
  input  wire [tae_pkg::WGT_W-1:0]         in_weight_value,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic signed [tae_pkg::VAL_W-1:0] out_action_out,
  output logic [tae_pkg::DIM_W-1:0]        out_dim,
  output logic                             out_last_dim
);
  import tae_pkg::*;

  logic          q_valid;
  tae_op_t       q_op;
  logic          q_pop;
  tae_div_req_t  div_req;
  tae_div_res_t  div_res;

  // Input classification and queue.
  tae_front #(.CHUNK_LEN(CHUNK_LEN), .NUM_DIMS(NUM_DIMS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_slot         (in_slot),
    .in_dim_index    (in_dim_index),
    .in_action_value (in_action_value),
    .in_weight_value (in_weight_value),
    .q_valid         (q_valid),
    .q_op            (q_op),
    .q_pop           (q_pop)
  );

  // Blend sequencer with its tables and history.
  tae_back #(.CHUNK_LEN(CHUNK_LEN), .NUM_DIMS(NUM_DIMS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .q_pop          (q_pop),
    .div_req        (div_req),
    .div_res        (div_res),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action_out (out_action_out),
    .out_dim        (out_dim),
    .out_last_dim   (out_last_dim)
  );

  // Rounding divider.
  tae_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

endmodule

`default_nettype wire
